@@ src/fba_pkg.sv @@
// Shared types, codes and field widths of the FAT block allocator.
`default_nettype none

package fba_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned BLK_W    = 11;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned FREED_W  = 12;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_LINK   = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  // Table entry encodings
  localparam logic [ENTRY_W-1:0] E_FREE = 16'h0000;
  localparam logic [ENTRY_W-1:0] E_RESV = 16'hFFFE;
  localparam logic [ENTRY_W-1:0] E_END  = 16'hFFFF;

endpackage

`default_nettype wire

@@ src/fba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/fat_block_allocator.sv @@
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------------
// request  | in        | in_valid_i / in_ready_o | kind, block_index, next_index, link_is_end,
//          |           |                         | start_hint, block_count
// response | out       | out_valid_o/out_ready_i | status, found_block, entry_value,
//          |           |                         | freed_count, last
//
// One request at a time; every table access goes through the single table RAM port pair.
// Allocate: scans entries, reserving free ones, then returns the blocks reserved one per
// response; a shortage first releases every reserved block. Free chain: walks and frees
// each entry in turn. Read: reads one entry. Link: writes one entry. Format: sweeps all ENTRIES.
// After reset the table is swept to its formatted state with in_ready_o low.
// A stalled response holds in the output register; the next request is still taken.
`default_nettype none

module fat_block_allocator #(
  parameter int unsigned ENTRIES = 2048,
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fba_pkg::KIND_W-1:0]     kind_i,
  input  logic [fba_pkg::BLK_W-1:0]      block_index_i,
  input  logic [fba_pkg::BLK_W-1:0]      next_index_i,
  input  logic                           link_is_end_i,
  input  logic [fba_pkg::BLK_W-1:0]      start_hint_i,
  input  logic [fba_pkg::CNT_W-1:0]      block_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fba_pkg::STATUS_W-1:0]   status_o,
  output logic [fba_pkg::BLK_W-1:0]      found_block_o,
  output logic [fba_pkg::ENTRY_W-1:0]    entry_value_o,
  output logic [fba_pkg::FREED_W-1:0]    freed_count_o,
  output logic                           last_o
);

  import fba_pkg::*;

  localparam int unsigned AW  = $clog2(ENTRIES);
  localparam int unsigned AW1 = AW + 1;
  localparam int unsigned RW  = $clog2(MAX_RUN + 1);
  localparam int unsigned PW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  localparam logic [AW:0]   ENT_A   = AW1'(ENTRIES);
  localparam logic [16:0]   ENT_W   = 17'(ENTRIES);
  localparam logic [AW-1:0] LAST_A  = AW'(ENTRIES - 1);
  localparam logic [AW-1:0] SEEN_LIM = AW'(ENTRIES - 3);
  localparam logic [AW-1:0] FIRST_DATA = AW'(2);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FMT, S_SCAN, S_UNDO, S_EM_RD, S_EM_LD,
    S_FC_RD, S_FC_CHK, S_RD_RD, S_RD_CAP, S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         chk_addr_q, chk_addr_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [AW-1:0]         seen_q, seen_d;
  logic [RW-1:0]         run_idx_q, run_idx_d;
  logic [RW-1:0]         run_n_q, run_n_d;
  logic [RW-1:0]         aux_idx_q, aux_idx_d;
  logic                  undo_vld_q, undo_vld_d;
  logic [AW-1:0]         freed_q, freed_d;
  status_e               rsp_st_q, rsp_st_d;
  logic [BLK_W-1:0]      rsp_blk_q, rsp_blk_d;
  logic [ENTRY_W-1:0]    rsp_ent_q, rsp_ent_d;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [BLK_W-1:0]      out_found_q, out_found_d;
  logic [ENTRY_W-1:0]    out_entry_q, out_entry_d;
  logic [FREED_W-1:0]    out_freed_q, out_freed_d;
  logic                  out_last_q, out_last_d;

  // Table and run store ports
  logic                  tbl_we, tbl_re;
  logic [AW-1:0]         tbl_waddr, tbl_raddr;
  logic [ENTRY_W-1:0]    tbl_wdata, tbl_rdata;
  logic                  pnd_we, pnd_re;
  logic [PW-1:0]         pnd_waddr, pnd_raddr;
  logic [AW-1:0]         pnd_rdata;

  // Helpers
  logic                  accept, slot_free;
  logic                  bi_data, nx_data, hint_data, bi_in_table, v_data;
  logic [AW:0]           cur_inc;
  logic [AW-1:0]         cur_wrap;
  logic [RW-1:0]         run_req;
  logic [RW-1:0]         run_inc, aux_inc;

  fba_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  fba_ram #(.WIDTH(AW), .DEPTH(MAX_RUN)) u_run (
    .clk_i  (clk_i),
    .we_i   (pnd_we),
    .waddr_i(pnd_waddr),
    .wdata_i(chk_addr_q),
    .re_i   (pnd_re),
    .raddr_i(pnd_raddr),
    .rdata_o(pnd_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Index range checks
  assign bi_in_table = 17'(block_index_i) < ENT_W;
  assign bi_data     = bi_in_table && (block_index_i >= BLK_W'(2));
  assign nx_data     = (17'(next_index_i) < ENT_W) && (next_index_i >= BLK_W'(2));
  assign hint_data   = (17'(start_hint_i) < ENT_W) && (start_hint_i >= BLK_W'(2));
  assign v_data      = (17'(tbl_rdata) < ENT_W) && (tbl_rdata >= ENTRY_W'(2));

  // Circular scan step over the data entries
  assign cur_inc  = AW1'(cur_q) + AW1'(1);
  assign cur_wrap = (cur_inc >= ENT_A) ? FIRST_DATA : cur_inc[AW-1:0];

  assign run_req = (block_count_i > CNT_W'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(block_count_i);
  assign run_inc = run_idx_q + RW'(1);
  assign aux_inc = aux_idx_q + RW'(1);

  // Sequencer next state and memory control
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    chk_addr_d   = chk_addr_q;
    chk_vld_d    = chk_vld_q;
    seen_d       = seen_q;
    run_idx_d    = run_idx_q;
    run_n_d      = run_n_q;
    aux_idx_d    = aux_idx_q;
    undo_vld_d   = undo_vld_q;
    freed_d      = freed_q;
    rsp_st_d     = rsp_st_q;
    rsp_blk_d    = rsp_blk_q;
    rsp_ent_d    = rsp_ent_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_entry_d  = out_entry_q;
    out_freed_d  = out_freed_q;
    out_last_d   = out_last_q;
    tbl_we       = 1'b0;
    tbl_waddr    = clr_q;
    tbl_wdata    = E_FREE;
    tbl_re       = 1'b0;
    tbl_raddr    = cur_q;
    pnd_we       = 1'b0;
    pnd_waddr    = run_idx_q[PW-1:0];
    pnd_re       = 1'b0;
    pnd_raddr    = aux_idx_q[PW-1:0];

    case (state_q)
      // Sweep the table to its formatted contents
      S_CLEAR, S_FMT: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = (clr_q < FIRST_DATA) ? E_END : E_FREE;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_A) begin
          state_d = (state_q == S_CLEAR) ? S_IDLE : S_RESP;
        end
      end

      // Decode a new transaction
      S_IDLE: begin
        if (accept) begin
          rsp_st_d  = STAT_OK;
          rsp_blk_d = block_index_i;
          rsp_ent_d = E_FREE;
          freed_d   = '0;
          case (kind_e'(kind_i))
            KIND_FORMAT: begin
              clr_d   = '0;
              state_d = S_FMT;
            end
            KIND_ALLOC: begin
              if (block_count_i == '0) begin
                rsp_blk_d = '0;
                state_d   = S_RESP;
              end else begin
                run_n_d   = run_req;
                run_idx_d = '0;
                seen_d    = '0;
                chk_vld_d = 1'b0;
                cur_d     = hint_data ? AW'(start_hint_i) : FIRST_DATA;
                state_d   = S_SCAN;
              end
            end
            KIND_LINK: begin
              if (!bi_data || (!link_is_end_i && !nx_data)) begin
                rsp_st_d = STAT_RANGE;
              end else begin
                tbl_we    = 1'b1;
                tbl_waddr = AW'(block_index_i);
                tbl_wdata = link_is_end_i ? E_END : ENTRY_W'(next_index_i);
              end
              state_d = S_RESP;
            end
            KIND_FREE: begin
              if (!bi_data) begin
                rsp_st_d = STAT_RANGE;
                state_d  = S_RESP;
              end else begin
                cur_d   = AW'(block_index_i);
                state_d = S_FC_RD;
              end
            end
            KIND_READ: begin
              if (!bi_in_table) begin
                rsp_st_d = STAT_RANGE;
                state_d  = S_RESP;
              end else begin
                cur_d   = AW'(block_index_i);
                state_d = S_RD_RD;
              end
            end
            default: begin
              rsp_st_d = STAT_RANGE;
              state_d  = S_RESP;
            end
          endcase
        end
      end

      // Stream reads around the table; reserve free entries as they arrive
      S_SCAN: begin
        tbl_re     = 1'b1;
        tbl_raddr  = cur_q;
        chk_addr_d = cur_q;
        chk_vld_d  = 1'b1;
        cur_d      = cur_wrap;
        if (chk_vld_q) begin
          seen_d = seen_q + AW'(1);
          if (tbl_rdata == E_FREE) begin
            tbl_we    = 1'b1;
            tbl_waddr = chk_addr_q;
            tbl_wdata = E_RESV;
            pnd_we    = 1'b1;
            run_idx_d = run_inc;
          end
          if ((tbl_rdata == E_FREE) && (run_inc == run_n_q)) begin
            aux_idx_d = '0;
            state_d   = S_EM_RD;
          end else if (seen_q == SEEN_LIM) begin
            aux_idx_d  = '0;
            undo_vld_d = 1'b0;
            state_d    = S_UNDO;
          end
        end
      end

      // Release the blocks reserved by a failed allocation
      S_UNDO: begin
        if (aux_idx_q != run_idx_q) begin
          pnd_re     = 1'b1;
          aux_idx_d  = aux_inc;
          undo_vld_d = 1'b1;
        end else begin
          undo_vld_d = 1'b0;
        end
        if (undo_vld_q) begin
          tbl_we    = 1'b1;
          tbl_waddr = pnd_rdata;
          tbl_wdata = E_FREE;
        end
        if ((aux_idx_q == run_idx_q) && !undo_vld_q) begin
          rsp_st_d  = STAT_NOSPACE;
          rsp_blk_d = '0;
          state_d   = S_RESP;
        end
      end

      // Return the reserved run one block per transaction
      S_EM_RD: begin
        pnd_re  = 1'b1;
        state_d = S_EM_LD;
      end

      S_EM_LD: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_found_d  = BLK_W'(pnd_rdata);
          out_entry_d  = '0;
          out_freed_d  = '0;
          out_last_d   = (aux_inc == run_n_q);
          aux_idx_d    = aux_inc;
          state_d      = (aux_inc == run_n_q) ? S_IDLE : S_EM_RD;
        end
      end

      // Walk a chain, freeing each entry
      S_FC_RD: begin
        tbl_re  = 1'b1;
        state_d = S_FC_CHK;
      end

      S_FC_CHK: begin
        if (tbl_rdata == E_FREE) begin
          state_d = S_RESP;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = cur_q;
          tbl_wdata = E_FREE;
          freed_d   = freed_q + AW'(1);
          if (v_data) begin
            cur_d   = AW'(tbl_rdata);
            state_d = S_FC_RD;
          end else begin
            state_d = S_RESP;
          end
        end
      end

      // Read one entry
      S_RD_RD: begin
        tbl_re  = 1'b1;
        state_d = S_RD_CAP;
      end

      S_RD_CAP: begin
        rsp_ent_d = tbl_rdata;
        state_d   = S_RESP;
      end

      // Hand the single response to the output register
      S_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = rsp_st_q;
          out_found_d  = rsp_blk_q;
          out_entry_d  = rsp_ent_q;
          out_freed_d  = FREED_W'(freed_q);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cur_q        <= '0;
      chk_addr_q   <= '0;
      chk_vld_q    <= 1'b0;
      seen_q       <= '0;
      run_idx_q    <= '0;
      run_n_q      <= '0;
      aux_idx_q    <= '0;
      undo_vld_q   <= 1'b0;
      freed_q      <= '0;
      rsp_st_q     <= STAT_OK;
      rsp_blk_q    <= '0;
      rsp_ent_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_found_q  <= '0;
      out_entry_q  <= '0;
      out_freed_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cur_q        <= cur_d;
      chk_addr_q   <= chk_addr_d;
      chk_vld_q    <= chk_vld_d;
      seen_q       <= seen_d;
      run_idx_q    <= run_idx_d;
      run_n_q      <= run_n_d;
      aux_idx_q    <= aux_idx_d;
      undo_vld_q   <= undo_vld_d;
      freed_q      <= freed_d;
      rsp_st_q     <= rsp_st_d;
      rsp_blk_q    <= rsp_blk_d;
      rsp_ent_q    <= rsp_ent_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_entry_q  <= out_entry_d;
      out_freed_q  <= out_freed_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_block_o = out_found_q;
  assign entry_value_o = out_entry_q;
  assign freed_count_o = out_freed_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  // The sequencer has ready low in the cycle after it takes a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while sequencer still busy");

  // Reservations never land on the system entries
  a_reserve_data_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && tbl_we |-> (chk_addr_q >= FIRST_DATA))
    else $error("scan wrote a system entry");

  // Emission stays inside the reserved run
  a_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EM_LD) |-> (aux_idx_q < run_n_q))
    else $error("emission index past run length");

  // Rollback never reads past the blocks reserved
  a_undo_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNDO) |-> (aux_idx_q <= run_idx_q))
    else $error("rollback index past reserved count");
`endif

endmodule

`default_nettype wire
